### rtl/stdet_pkg.sv
`default_nettype none

package stdet_pkg;

    // Default build-time sizes
    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int MAX_WINDOW_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int IDX_W      = 16;
    localparam int WLEN_W     = 13;
    localparam int PAD_W      = 15;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register reset values
    localparam logic [WLEN_W-1:0] WLEN_RESET = 13'd480;
    localparam logic [PAD_W-1:0]  PAD_RESET  = 15'd4800;

    // Register map, selected by paddr[2]
    typedef enum logic [0:0] {
        REG_WINDOW_LEN = 1'b0,
        REG_PAD_LEN    = 1'b1
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SUM0,
        ST_THR,
        ST_NOISE,
        ST_FWD_REM,
        ST_FWD_ADD,
        ST_BSUM,
        ST_BK_REM,
        ST_BK_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/stdet_ram.sv
`default_nettype none

module stdet_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/silence_trim_detector.sv
`default_nettype none

// Silence trim detector. A recording streams in one sample per cycle (start high,
// busy low); the sample with i_last set ends it. The block then goes busy and
// scans the stored recording through the single read port of the sample RAM,
// one sample at a time: each W-sample window sum reads its samples in turn, and
// each step of the forward and backward scans reads the sample leaving the
// window, then the one entering it. A short recording skips the scans. The
// result shows for exactly one cycle on o_result_valid and cannot be held off;
// busy is already low in that cycle, so the next recording may begin at once.
// The user must write registers only while busy is low; the block itself does
// not enforce it. New values written while idle apply to the next recording.
module silence_trim_detector #(
    parameter int MAX_SAMPLES = stdet_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_WINDOW  = stdet_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = stdet_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // item input
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  wire logic                                 i_last,
    // result output
    output logic                                      o_result_valid,
    output logic [stdet_pkg::IDX_W-1:0]               o_start_index,
    output logic [stdet_pkg::IDX_W-1:0]               o_stop_index,
    output logic                                      o_empty_range,
    output logic                                      o_untouched,
    output logic                                      o_high_noise,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [stdet_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [stdet_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [stdet_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                      pready
);

    localparam int IDX_W  = stdet_pkg::IDX_W;
    localparam int WLEN_W = stdet_pkg::WLEN_W;
    localparam int PAD_W  = stdet_pkg::PAD_W;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = WIN_W + SAMPLE_BITS - 1;
    localparam int THR_W  = SUM_W + 2;
    localparam int HN_W   = SUM_W + 5;
    localparam int MAX_IW = (CNT_W > PAD_W) ? CNT_W : PAD_W;
    localparam int POS_W  = ((MAX_IW > WIN_W) ? MAX_IW : WIN_W) + 2;

    stdet_pkg::t_state r_state, n_state;

    logic [WLEN_W-1:0] r_window_len;
    logic [PAD_W-1:0]  r_pad_len;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_front, n_front;
    logic signed [POS_W-1:0] r_back, n_back;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [THR_W-1:0]  r_thr, n_thr;
    logic              r_hn, n_hn;
    logic              r_pend, n_pend;
    logic signed [POS_W-1:0] r_keep_b, n_keep_b;
    logic signed [POS_W-1:0] r_keep_e, n_keep_e;

    logic              r_result_valid, n_result_valid;
    logic [IDX_W-1:0]  r_start_index, n_start_index;
    logic [IDX_W-1:0]  r_stop_index, n_stop_index;
    logic              r_empty_range, n_empty_range;
    logic              r_untouched, n_untouched;
    logic              r_high_noise, n_high_noise;

    logic [WIN_W-1:0]        w_eff;
    logic [SAMPLE_BITS-1:0]  rd_data;
    logic [SAMPLE_BITS-1:0]  rd_mag;
    logic [SUM_W-1:0]        s_cur;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic                    load_accept;
    logic                    short_rec;
    logic                    fwd_go;
    logic                    bk_go;
    logic                    empty_now;
    logic signed [POS_W-1:0] cnt_s, front_s, w_s, pad_s;
    logic signed [POS_W-1:0] pad_b, pad_e, last_s;

    // Sample store
    stdet_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_sample),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Configuration port
    assign pready = 1'b1;

    always_comb begin
        case (stdet_pkg::t_reg_idx'(paddr[2]))
            stdet_pkg::REG_WINDOW_LEN: prdata = stdet_pkg::CFG_DATA_W'(r_window_len);
            stdet_pkg::REG_PAD_LEN:    prdata = stdet_pkg::CFG_DATA_W'(r_pad_len);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= stdet_pkg::WLEN_RESET;
            r_pad_len    <= stdet_pkg::PAD_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (stdet_pkg::t_reg_idx'(paddr[2]))
                stdet_pkg::REG_WINDOW_LEN: r_window_len <= pwdata[WLEN_W-1:0];
                stdet_pkg::REG_PAD_LEN:    r_pad_len    <= pwdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective window: zero reads as one, long windows saturate
    always_comb begin
        if (r_window_len == '0) begin
            w_eff = WIN_W'(1);
        end else if (32'(r_window_len) > 32'(MAX_WINDOW)) begin
            w_eff = WIN_W'(MAX_WINDOW);
        end else begin
            w_eff = WIN_W'(r_window_len);
        end
    end

    // Shared helpers
    assign busy        = (r_state != stdet_pkg::ST_LOAD);
    assign load_accept = start && !busy;
    assign short_rec   = (32'(r_count) < 32'({r_pad_len, 1'b0}))
                      || (32'(r_count) < 32'(w_eff));
    assign rd_mag      = rd_data[SAMPLE_BITS-1] ? (~rd_data + SAMPLE_BITS'(1)) : rd_data;
    assign s_cur       = r_sum + (r_pend ? SUM_W'(rd_mag) : '0);

    assign cnt_s   = $signed(POS_W'(r_count));
    assign front_s = $signed(POS_W'(r_front));
    assign w_s     = $signed(POS_W'(w_eff));
    assign pad_s   = $signed(POS_W'(r_pad_len));
    assign last_s  = cnt_s - POS_W'(1);
    assign pad_b   = front_s - pad_s;
    assign pad_e   = r_back + pad_s;

    assign fwd_go    = (r_front < r_count) && (THR_W'(s_cur) < r_thr);
    assign bk_go     = (r_back > front_s) && (THR_W'(s_cur) < r_thr);
    assign empty_now = (r_keep_b > r_keep_e);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stdet_pkg::ST_LOAD: begin
                if (load_accept && i_last) begin
                    n_state = stdet_pkg::ST_CHECK;
                end
            end
            stdet_pkg::ST_CHECK: begin
                n_state = short_rec ? stdet_pkg::ST_LOAD : stdet_pkg::ST_SUM0;
            end
            stdet_pkg::ST_SUM0: begin
                if (32'(r_idx) == 32'(w_eff) - 32'd1) begin
                    n_state = stdet_pkg::ST_THR;
                end
            end
            stdet_pkg::ST_THR:     n_state = stdet_pkg::ST_NOISE;
            stdet_pkg::ST_NOISE:   n_state = stdet_pkg::ST_FWD_REM;
            stdet_pkg::ST_FWD_REM: begin
                n_state = fwd_go ? stdet_pkg::ST_FWD_ADD : stdet_pkg::ST_BSUM;
            end
            stdet_pkg::ST_FWD_ADD: n_state = stdet_pkg::ST_FWD_REM;
            stdet_pkg::ST_BSUM: begin
                if (r_idx == r_count - CNT_W'(1)) begin
                    n_state = stdet_pkg::ST_BK_REM;
                end
            end
            stdet_pkg::ST_BK_REM: begin
                n_state = bk_go ? stdet_pkg::ST_BK_ADD : stdet_pkg::ST_PAD;
            end
            stdet_pkg::ST_BK_ADD:  n_state = stdet_pkg::ST_BK_REM;
            stdet_pkg::ST_PAD:     n_state = stdet_pkg::ST_EMIT;
            stdet_pkg::ST_EMIT:    n_state = stdet_pkg::ST_LOAD;
            default:               n_state = stdet_pkg::ST_LOAD;
        endcase
    end

    // Datapath and outputs. Each scan step reads the sample leaving the
    // window, then the one entering; the entering sample is added on the
    // following cycle together with the loop test.
    always_comb begin
        n_count        = r_count;
        n_idx          = r_idx;
        n_front        = r_front;
        n_back         = r_back;
        n_sum          = r_sum;
        n_thr          = r_thr;
        n_hn           = r_hn;
        n_pend         = 1'b0;
        n_keep_b       = r_keep_b;
        n_keep_e       = r_keep_e;
        n_result_valid = 1'b0;
        n_start_index  = r_start_index;
        n_stop_index   = r_stop_index;
        n_empty_range  = r_empty_range;
        n_untouched    = r_untouched;
        n_high_noise   = r_high_noise;
        rd_addr        = '0;
        wr_en          = 1'b0;
        case (r_state)
            stdet_pkg::ST_LOAD: begin
                // store while there is room; a last mark still ends the item run
                if (load_accept && (32'(r_count) < 32'(MAX_SAMPLES))) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            stdet_pkg::ST_CHECK: begin
                if (short_rec) begin
                    n_result_valid = 1'b1;
                    n_start_index  = '0;
                    n_stop_index   = IDX_W'(r_count - CNT_W'(1));
                    n_empty_range  = 1'b0;
                    n_untouched    = 1'b1;
                    n_high_noise   = 1'b0;
                    n_count        = '0;
                end else begin
                    n_idx = '0;
                    n_sum = '0;
                end
            end
            stdet_pkg::ST_SUM0: begin
                rd_addr = r_idx[ADDR_W-1:0];
                n_sum   = s_cur;
                n_pend  = 1'b1;
                n_idx   = r_idx + CNT_W'(1);
            end
            stdet_pkg::ST_THR: begin
                n_sum = s_cur;
            end
            stdet_pkg::ST_NOISE: begin
                // threshold 3*S0; noisy when 30*S0 >= W * full scale
                n_thr   = THR_W'(r_sum) + THR_W'({r_sum, 1'b0});
                n_hn    = (HN_W'({r_sum, 5'b0}) - HN_W'({r_sum, 1'b0}))
                       >= HN_W'({w_eff, {(SAMPLE_BITS-1){1'b0}}});
                n_front = CNT_W'(w_eff);
            end
            stdet_pkg::ST_FWD_REM: begin
                n_sum = s_cur;
                if (fwd_go) begin
                    rd_addr = ADDR_W'(r_front - CNT_W'(w_eff));
                end else begin
                    n_idx  = r_count - CNT_W'(w_eff);
                    n_sum  = '0;
                    n_back = cnt_s - POS_W'(1) - w_s;
                end
            end
            stdet_pkg::ST_FWD_ADD: begin
                n_sum   = r_sum - SUM_W'(rd_mag);
                rd_addr = r_front[ADDR_W-1:0];
                n_pend  = 1'b1;
                n_front = r_front + CNT_W'(1);
            end
            stdet_pkg::ST_BSUM: begin
                rd_addr = r_idx[ADDR_W-1:0];
                n_sum   = s_cur;
                n_pend  = 1'b1;
                n_idx   = r_idx + CNT_W'(1);
            end
            stdet_pkg::ST_BK_REM: begin
                n_sum = s_cur;
                if (bk_go) begin
                    rd_addr = ADDR_W'(r_back + w_s);
                end
            end
            stdet_pkg::ST_BK_ADD: begin
                n_sum   = r_sum - SUM_W'(rd_mag);
                rd_addr = ADDR_W'(r_back);
                n_pend  = 1'b1;
                n_back  = r_back - POS_W'(1);
            end
            stdet_pkg::ST_PAD: begin
                // widen by the padding, clamped to the recording
                n_keep_b = (pad_b < 0) ? '0 : pad_b;
                n_keep_e = (pad_e > last_s) ? last_s : pad_e;
            end
            stdet_pkg::ST_EMIT: begin
                n_result_valid = 1'b1;
                n_empty_range  = empty_now;
                n_start_index  = empty_now ? '0 : IDX_W'(r_keep_b);
                n_stop_index   = empty_now ? '0 : IDX_W'(r_keep_e);
                n_untouched    = 1'b0;
                n_high_noise   = r_hn;
                n_count        = '0;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= stdet_pkg::ST_LOAD;
            r_count        <= '0;
            r_pend         <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_pend         <= n_pend;
            r_result_valid <= n_result_valid;
        end
    end

    // Datapath and result registers
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_front       <= n_front;
        r_back        <= n_back;
        r_sum         <= n_sum;
        r_thr         <= n_thr;
        r_hn          <= n_hn;
        r_keep_b      <= n_keep_b;
        r_keep_e      <= n_keep_e;
        r_start_index <= n_start_index;
        r_stop_index  <= n_stop_index;
        r_empty_range <= n_empty_range;
        r_untouched   <= n_untouched;
        r_high_noise  <= n_high_noise;
    end

    assign o_result_valid = r_result_valid;
    assign o_start_index  = r_start_index;
    assign o_stop_index   = r_stop_index;
    assign o_empty_range  = r_empty_range;
    assign o_untouched    = r_untouched;
    assign o_high_noise   = r_high_noise;

`ifndef NO_ASSERTIONS
    // a result always leaves the block ready for the next recording
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result_valid |-> (!busy && (r_count == '0)))
        else $error("result shown while busy or with samples counted");

    // an accepted last sample always makes the block busy
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy)
        else $error("last item accepted but block not busy");

    // forward scan only reads samples of the current recording
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stdet_pkg::ST_FWD_ADD) |-> (r_front < r_count))
        else $error("forward scan beyond recording");

    // backward scan stays behind the forward position
    a_bk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stdet_pkg::ST_BK_ADD) |-> (r_back > front_s))
        else $error("backward scan crossed forward position");
`endif

endmodule

`default_nettype wire

### test/silence_trim_detector_test.sv
`timescale 1ns / 100ps

module silence_trim_detector_test;

    localparam int SW          = stdet_pkg::SAMPLE_BITS_DEF;
    localparam int IDX_W       = stdet_pkg::IDX_W;
    localparam int WLEN_W      = stdet_pkg::WLEN_W;
    localparam int PAD_W       = stdet_pkg::PAD_W;
    localparam int CFG_ADDR_W  = stdet_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W  = stdet_pkg::CFG_DATA_W;
    localparam int STALL_LIMIT = 600000;

    typedef struct packed {
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] stop_index;
        logic             empty_range;
        logic             untouched;
        logic             high_noise;
    } t_trim_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [SW-1:0]  i_sample;
    logic                  i_last;
    logic                  o_result_valid;
    logic [IDX_W-1:0]      o_start_index;
    logic [IDX_W-1:0]      o_stop_index;
    logic                  o_empty_range;
    logic                  o_untouched;
    logic                  o_high_noise;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Local copy of the registers and of the recording being loaded
    logic [WLEN_W-1:0] window_setting = stdet_pkg::WLEN_RESET;
    logic [PAD_W-1:0]  pad_setting    = stdet_pkg::PAD_RESET;
    int                rec_samples[$];
    t_trim_result      expected_trims[$];
    int                idle_pct    = 14;
    int                items_sent  = 0;
    int                stall_count = 0;
    bit                mismatch_seen = 1'b0;

    silence_trim_detector u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_result_valid (o_result_valid),
        .o_start_index  (o_start_index),
        .o_stop_index   (o_stop_index),
        .o_empty_range  (o_empty_range),
        .o_untouched    (o_untouched),
        .o_high_noise   (o_high_noise),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    function automatic longint sample_mag(longint idx);
        int v = rec_samples[idx];
        return (v < 0) ? -v : v;
    endfunction

    // Trim range of the recording held in rec_samples, under the current settings
    function automatic t_trim_result predict_trim();
        longint n, w, pad, s, thr, fwd, bwd, b, e, i;
        t_trim_result r;
        r   = '0;
        n   = rec_samples.size();
        w   = window_setting;
        pad = pad_setting;
        if (w < 1) w = 1;
        if (w > stdet_pkg::MAX_WINDOW_DEF) w = stdet_pkg::MAX_WINDOW_DEF;

        // too short: whole range kept
        if (n < 2 * pad || n < w) begin
            r.stop_index = IDX_W'(n - 1);
            r.untouched  = 1'b1;
            return r;
        end

        // noise floor from the opening window
        s = 0;
        for (i = 0; i < w; i++) s += sample_mag(i);
        thr          = 3 * s;
        r.high_noise = (30 * s >= w * (longint'(1) << (SW - 1)));

        // forward scan for the first loud window
        fwd = w;
        while (fwd < n && s < thr) begin
            s = s - sample_mag(fwd - w) + sample_mag(fwd);
            fwd++;
        end

        // backward scan from the closing window
        s = 0;
        for (i = n - w; i < n; i++) s += sample_mag(i);
        bwd = n - 1 - w;
        while (bwd > fwd && s < thr) begin
            s = s - sample_mag(bwd + w) + sample_mag(bwd);
            bwd--;
        end

        // widen by the padding, clamped to the recording
        b = fwd - pad;
        if (b < 0) b = 0;
        e = bwd + pad;
        if (e > n - 1) e = n - 1;
        if (b > e) begin
            r.empty_range = 1'b1;
        end else begin
            r.start_index = IDX_W'(b);
            r.stop_index  = IDX_W'(e);
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] quiet_sample(int amp);
        logic signed [SW-1:0] v;
        v = SW'($urandom_range(amp));
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    // One item: optional idle gap, then hold start until busy is low at an edge
    task automatic send_sample(input logic signed [SW-1:0] value, input logic last_flag);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= value;
        i_last   <= last_flag;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (rec_samples.size() < stdet_pkg::MAX_SAMPLES_DEF)
            rec_samples.insert(rec_samples.size(), int'(value));
        if (last_flag) begin
            expected_trims.insert(expected_trims.size(), predict_trim());
            rec_samples.delete();
        end
    endtask

    // Block quiet: no result pending and not busy
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_trims.size() != 0 || busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input stdet_pkg::t_reg_idx idx, input logic wr,
                                input logic [CFG_DATA_W-1:0] wdata,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input stdet_pkg::t_reg_idx idx);
        logic [CFG_DATA_W-1:0] rdata;
        apb_transfer(idx, 1'b0, '0, rdata);
        if (idx == stdet_pkg::REG_WINDOW_LEN)
            check_field("window_len", window_setting, rdata[WLEN_W-1:0]);
        else
            check_field("pad_len", pad_setting, rdata[PAD_W-1:0]);
    endtask

    // Write with random junk above the register width, then read back
    task automatic write_register(input stdet_pkg::t_reg_idx idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] wdata, rdata;
        wdata = $urandom();
        if (idx == stdet_pkg::REG_WINDOW_LEN) begin
            wdata[WLEN_W-1:0] = value[WLEN_W-1:0];
            window_setting    = value[WLEN_W-1:0];
        end else begin
            wdata[PAD_W-1:0]  = value[PAD_W-1:0];
            pad_setting       = value[PAD_W-1:0];
        end
        apb_transfer(idx, 1'b1, wdata, rdata);
        check_register(idx);
    endtask

    task automatic write_settings(input int unsigned wlen, input int unsigned pad);
        wait_idle();
        write_register(stdet_pkg::REG_WINDOW_LEN, wlen);
        write_register(stdet_pkg::REG_PAD_LEN, pad);
    endtask

    // Reset settings: every short recording comes back untouched
    task automatic test_short_recordings();
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b1);
    endtask

    task automatic test_trim_cases();
        int i;
        write_settings(4, 0);
        // silent start: zero threshold, range comes out empty
        for (i = 0; i < 5; i++) send_sample(16'sd0, i == 4);
        // burst of sound between quiet stretches
        for (i = 0; i < 4; i++) send_sample((i % 2) ? -16'sd1 : 16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd2000, 1'b0);
        send_sample(-16'sd2000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b1);
        // loud opening window raises the noise flag
        for (i = 0; i < 4; i++) send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
    endtask

    task automatic test_window_extremes();
        // zero window behaves as one
        write_settings(0, 1);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd30000, 1'b0);
        send_sample(16'sd0, 1'b1);
        // largest window, recording shorter than it
        write_settings(stdet_pkg::MAX_WINDOW_DEF, 0);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd5, 1'b1);
    endtask

    task automatic randomize_settings();
        int unsigned wlen, pad, pick;
        pick = $urandom_range(9);
        if (pick == 0)      wlen = 0;
        else if (pick < 8)  wlen = $urandom_range(12, 1);
        else                wlen = $urandom_range(40, 13);
        pick = $urandom_range(9);
        if (pick < 6)       pad = $urandom_range(4);
        else if (pick < 8)  pad = $urandom_range(20, 5);
        else                pad = $urandom_range(60, 21);
        write_settings(wlen, pad);
    endtask

    // Mostly quiet-loud-quiet recordings, some pure noise and some silence
    task automatic play_random_recording();
        int len, style, amp, lead, loud, i;
        logic signed [SW-1:0] v;
        len   = ($urandom_range(4) == 0) ? $urandom_range(120, 49) : $urandom_range(48, 1);
        style = $urandom_range(9);
        amp   = $urandom_range(40);
        lead  = $urandom_range(len);
        loud  = $urandom_range(len - lead);
        for (i = 0; i < len; i++) begin
            if (style == 9)
                v = '0;
            else if (style >= 7 || (i >= lead && i < lead + loud))
                v = SW'($urandom());
            else
                v = quiet_sample(amp);
            send_sample(v, i == len - 1);
        end
    endtask

    task automatic test_random(input int idle, input int item_target);
        int first_item, recordings;
        idle_pct   = idle;
        first_item = items_sent;
        recordings = 0;
        while (items_sent - first_item < item_target || recordings < 16) begin
            if ($urandom_range(3) == 0) randomize_settings();
            play_random_recording();
            recordings++;
        end
    endtask

    // Window register at its widest, recording shorter than the saturated window
    task automatic test_long_window();
        int i;
        idle_pct = 0;
        write_settings(8191, 10);
        for (i = 0; i < 40; i++)
            send_sample((i >= 15 && i < 25) ? SW'($urandom()) : quiet_sample(20), i == 39);
    endtask

    // Result checker: the receiver cannot stall, so every strobe is taken
    always @(posedge i_clk) begin
        t_trim_result want;
        if (i_rst_n && o_result_valid) begin
            if (expected_trims.size() == 0) begin
                $error("result with no item waiting: start_index %0d stop_index %0d",
                       o_start_index, o_stop_index);
                mismatch_seen = 1'b1;
            end else begin
                want = expected_trims.pop_front();
                check_field("start_index", want.start_index, o_start_index);
                check_field("stop_index", want.stop_index, o_stop_index);
                check_field("empty_range", want.empty_range, o_empty_range);
                check_field("untouched", want.untouched, o_untouched);
                check_field("high_noise", want.high_noise, o_high_noise);
            end
        end
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || psel) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("silence_trim_detector: mismatch");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_sample <= '0;
        i_last   <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        @(posedge i_clk);

        check_register(stdet_pkg::REG_WINDOW_LEN);
        check_register(stdet_pkg::REG_PAD_LEN);
        test_short_recordings();
        test_trim_cases();
        test_window_extremes();
        test_random(14, 460);
        test_random(47, 460);
        test_random(0, 460);
        test_long_window();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (!mismatch_seen && expected_trims.size() == 0)
            $display("silence_trim_detector: match");
        else
            $display("silence_trim_detector: mismatch");
        $finish;
    end

endmodule
